// File: src/hpdd_pkg.sv
// ----------------------------------------------------------------------------
// hpdd_pkg
// Shared widths, types and the square-root step for the Hankel pair distance.
// ----------------------------------------------------------------------------
`default_nettype none

package hpdd_pkg;

  localparam int SAMPLE_WIDTH = 16;
  localparam int PAIR_W       = SAMPLE_WIDTH + 1;
  localparam int SQ_W         = 2 * PAIR_W;
  localparam int ACC_W        = 48;
  localparam int EXT_W        = ((SQ_W > ACC_W) ? SQ_W : ACC_W) + 1;
  localparam int ROOT_W       = ACC_W / 2 + 1;
  localparam int NUM_W        = ROOT_W + 2;
  localparam int DIST_W       = 32;
  localparam int FRAC_W       = 14;
  localparam int QUEUE_DEPTH  = 2;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

  // 2 + 2 in the root domain (roots carry 14 fraction bits), halved later
  localparam logic [NUM_W-1:0] FOUR_Q14 = NUM_W'(4) << FRAC_W;
  localparam logic [ACC_W-1:0] ROOT_PROBE_TOP = ACC_W'(1) << (ACC_W - 2);

  typedef struct packed {
    logic [ACC_W-1:0] x_total;
    logic [ACC_W-1:0] y_total;
  } totals_t;

  typedef struct packed {
    logic empty;
    logic full;
  } queue_status_t;

  typedef struct packed {
    logic [ACC_W-1:0] rem;
    logic [ACC_W-1:0] res;
  } root_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_ROOT,
    BK_HOLD
  } back_state_e;

  function automatic logic [ACC_W-1:0] sat_accumulate(logic [ACC_W-1:0] acc,
                                                      logic [SQ_W-1:0]  sq);
    logic [EXT_W-1:0] sum;
    sum = EXT_W'(acc) + EXT_W'(sq);
    if (|sum[EXT_W-1:ACC_W]) begin
      return {ACC_W{1'b1}};
    end
    return sum[ACC_W-1:0];
  endfunction

  function automatic root_t sqrt_step(root_t cur, logic [ACC_W-1:0] probe);
    logic [ACC_W:0] trial;
    root_t          nxt;
    trial = {1'b0, cur.res} + {1'b0, probe};
    if ({1'b0, cur.rem} >= trial) begin
      nxt.rem = cur.rem - trial[ACC_W-1:0];
      nxt.res = (cur.res >> 1) + probe;
    end else begin
      nxt.rem = cur.rem;
      nxt.res = cur.res >> 1;
    end
    return nxt;
  endfunction

endpackage

`default_nettype wire

// File: src/hpdd_if.sv
// ----------------------------------------------------------------------------
// hpdd_if
// Valid/ready channels for element items and distance results.
// ----------------------------------------------------------------------------
`default_nettype none

interface hpdd_in_if
  import hpdd_pkg::*;
  ;
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample_x_element;
  logic signed [SAMPLE_WIDTH-1:0] center_x_element;
  logic signed [SAMPLE_WIDTH-1:0] sample_y_element;
  logic signed [SAMPLE_WIDTH-1:0] center_y_element;
  logic                           last_element;

  modport source (
    output valid, sample_x_element, center_x_element, sample_y_element,
           center_y_element, last_element,
    input  ready
  );
  modport sink (
    input  valid, sample_x_element, center_x_element, sample_y_element,
           center_y_element, last_element,
    output ready
  );
endinterface

interface hpdd_out_if
  import hpdd_pkg::*;
  ;
  logic                     valid;
  logic                     ready;
  logic signed [DIST_W-1:0] distance;

  modport source (output valid, distance, input ready);
  modport sink (input valid, distance, output ready);
endinterface

`default_nettype wire

// File: src/hankel_pair_dynamic_distance.sv
// ----------------------------------------------------------------------------
// hankel_pair_dynamic_distance
// Squared-sum accumulation of two Hankel matrix pairs and root-based distance.
//
//   channel  | dir | payload                                  | transfer
//   ---------+-----+------------------------------------------+-------------
//   in_if    | in  | four Q2.14 elements, last_element flag   | valid&ready
//   out_if   | out | distance, signed Q18.14                  | valid&ready
//
// Accepts one element item per cycle while ready is high; the accumulator adds
// the squares registered by the multiply stage. Each last item yields a result
// once the root unit has resolved two bits per cycle for both totals.
// A two-entry queue of totals lets streaming continue while roots are taken;
// input stalls only when a last item finds that queue full.
// Reset clears the totals and all control state at once.
// ----------------------------------------------------------------------------
`default_nettype none

module hankel_pair_dynamic_distance
  import hpdd_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  hpdd_in_if.sink        in_if,
  hpdd_out_if.source     out_if
);

  queue_status_t q_status;
  logic          push, pop;
  totals_t       push_data, pop_data;

  hpdd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_ready_o  (in_if.ready),
    .sample_x_i  (in_if.sample_x_element),
    .center_x_i  (in_if.center_x_element),
    .sample_y_i  (in_if.sample_y_element),
    .center_y_i  (in_if.center_y_element),
    .last_i      (in_if.last_element),
    .q_status_i  (q_status),
    .push_o      (push),
    .push_data_o (push_data)
  );

  hpdd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .status_o    (q_status)
  );

  hpdd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_status_i  (q_status),
    .pop_data_i  (pop_data),
    .pop_o       (pop),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .distance_o  (out_if.distance)
  );

endmodule

`default_nettype wire

// File: src/hpdd_front.sv
// ----------------------------------------------------------------------------
// hpdd_front
// Accept element items, square the pair sums and accumulate both totals.
// ----------------------------------------------------------------------------
`default_nettype none

module hpdd_front
  import hpdd_pkg::*;
(
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output      logic                           in_ready_o,
  input  wire logic signed [SAMPLE_WIDTH-1:0] sample_x_i,
  input  wire logic signed [SAMPLE_WIDTH-1:0] center_x_i,
  input  wire logic signed [SAMPLE_WIDTH-1:0] sample_y_i,
  input  wire logic signed [SAMPLE_WIDTH-1:0] center_y_i,
  input  wire logic                           last_i,
  input  wire queue_status_t                  q_status_i,
  output      logic                           push_o,
  output      totals_t                        push_data_o
);

  logic              s1_valid_q, s1_valid_d;
  logic              s1_last_q;
  logic [SQ_W-1:0]   sq_x_q, sq_y_q;
  logic [ACC_W-1:0]  acc_x_q, acc_x_d, acc_y_q, acc_y_d;
  logic [ACC_W-1:0]  next_x, next_y;
  logic signed [PAIR_W-1:0] pair_x, pair_y;
  logic signed [SQ_W-1:0]   prod_x, prod_y;
  logic              accept;
  logic              advance;

  assign advance    = s1_valid_q && !(s1_last_q && q_status_i.full);
  assign in_ready_o = !(s1_valid_q && s1_last_q && q_status_i.full);
  assign accept     = in_valid_i && in_ready_o;

  assign pair_x = PAIR_W'(sample_x_i) + PAIR_W'(center_x_i);
  assign pair_y = PAIR_W'(sample_y_i) + PAIR_W'(center_y_i);
  assign prod_x = SQ_W'(pair_x) * SQ_W'(pair_x);
  assign prod_y = SQ_W'(pair_y) * SQ_W'(pair_y);

  assign next_x = sat_accumulate(acc_x_q, sq_x_q);
  assign next_y = sat_accumulate(acc_y_q, sq_y_q);

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (advance) begin
      s1_valid_d = 1'b0;
    end
  end

  always_comb begin
    acc_x_d = acc_x_q;
    acc_y_d = acc_y_q;
    if (advance) begin
      acc_x_d = s1_last_q ? '0 : next_x;
      acc_y_d = s1_last_q ? '0 : next_y;
    end
  end

  assign push_o              = advance && s1_last_q;
  assign push_data_o.x_total = next_x;
  assign push_data_o.y_total = next_y;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      acc_x_q    <= '0;
      acc_y_q    <= '0;
    end else begin
      s1_valid_q <= s1_valid_d;
      acc_x_q    <= acc_x_d;
      acc_y_q    <= acc_y_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_last_q <= last_i;
      sq_x_q    <= prod_x;
      sq_y_q    <= prod_y;
    end
  end

endmodule

`default_nettype wire

// File: src/hpdd_queue.sv
// ----------------------------------------------------------------------------
// hpdd_queue
// Short queue of finished totals between the accumulator and the root unit.
// ----------------------------------------------------------------------------
`default_nettype none

module hpdd_queue
  import hpdd_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    push_i,
  input  wire totals_t push_data_i,
  input  wire logic    pop_i,
  output      totals_t pop_data_o,
  output      queue_status_t status_o
);

  totals_t             entry_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0]   cnt_q, cnt_d;
  logic                do_push, do_pop;

  assign status_o.empty = (cnt_q == '0);
  assign status_o.full  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign do_push        = push_i && !status_o.full;
  assign do_pop         = pop_i && !status_o.empty;
  assign pop_data_o     = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

// File: src/hpdd_back.sv
// ----------------------------------------------------------------------------
// hpdd_back
// Take both square roots two bits a cycle and form the distance.
// ----------------------------------------------------------------------------
`default_nettype none

module hpdd_back
  import hpdd_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire queue_status_t            q_status_i,
  input  wire totals_t                  pop_data_i,
  output      logic                     pop_o,
  output      logic                     out_valid_o,
  input  wire logic                     out_ready_i,
  output      logic signed [DIST_W-1:0] distance_o
);

  back_state_e              state_q, state_d;
  root_t                    root_x_q, root_x_d, root_y_q, root_y_d;
  logic [ACC_W-1:0]         probe_q, probe_d;
  logic                     out_valid_q, out_valid_d;
  logic signed [DIST_W-1:0] dist_q;
  logic                     slot_free;
  logic                     load_out;
  logic [NUM_W-1:0]         num;
  logic signed [DIST_W-1:0] dist_new;

  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: if (!q_status_i.empty) state_d = BK_ROOT;
      BK_ROOT: if (probe_q[0]) state_d = BK_HOLD;
      BK_HOLD: if (slot_free) state_d = BK_IDLE;
      default: state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    pop_o    = 1'b0;
    load_out = 1'b0;
    case (state_q)
      BK_IDLE: pop_o    = !q_status_i.empty;
      BK_HOLD: load_out = slot_free;
      default: begin
        pop_o    = 1'b0;
        load_out = 1'b0;
      end
    endcase
  end

  always_comb begin
    root_x_d = root_x_q;
    root_y_d = root_y_q;
    probe_d  = probe_q;
    if (pop_o) begin
      root_x_d = '{rem: pop_data_i.x_total, res: '0};
      root_y_d = '{rem: pop_data_i.y_total, res: '0};
      probe_d  = ROOT_PROBE_TOP;
    end else if (state_q == BK_ROOT) begin
      root_x_d = sqrt_step(root_x_q, probe_q);
      root_y_d = sqrt_step(root_y_q, probe_q);
      probe_d  = probe_q >> 2;
    end
  end

  assign num      = FOUR_Q14 - NUM_W'(root_x_q.res[ROOT_W-1:0])
                             - NUM_W'(root_y_q.res[ROOT_W-1:0]);
  assign dist_new = DIST_W'($signed(num) >>> 1);

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    root_x_q <= root_x_d;
    root_y_q <= root_y_d;
    probe_q  <= probe_d;
    if (load_out) begin
      dist_q <= dist_new;
    end
  end

  assign out_valid_o = out_valid_q;
  assign distance_o  = dist_q;

endmodule

`default_nettype wire

// File: src/hpdd_checker.sv
// ----------------------------------------------------------------------------
// hpdd_checker
// Port-level checks on result ordering, capacity and distance range.
// ----------------------------------------------------------------------------
`default_nettype none

module hpdd_checker
  import hpdd_pkg::*;
(
  input wire logic                     clk_i,
  input wire logic                     rst_ni,
  input wire logic                     in_valid_i,
  input wire logic                     in_ready_i,
  input wire logic                     last_i,
  input wire logic                     out_valid_i,
  input wire logic                     out_ready_i,
  input wire logic signed [DIST_W-1:0] distance_i
);

  logic [3:0] pending_q, pending_d;
  logic       in_last_xfer, out_xfer;

  assign in_last_xfer = in_valid_i && in_ready_i && last_i;
  assign out_xfer     = out_valid_i && out_ready_i;

  always_comb begin
    pending_d = pending_q;
    case ({in_last_xfer, out_xfer})
      2'b10:   pending_d = pending_q + 1'b1;
      2'b01:   pending_d = pending_q - 1'b1;
      default: pending_d = pending_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_d;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(distance_i))
    else $error("result dropped or changed while stalled");

  a_result_has_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> pending_q != 4'd0)
    else $error("result without a preceding last element");

  a_capacity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q <= 4'd5)
    else $error("more open matrix pairs than the pipeline can hold");

  a_distance_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> distance_i <= (DIST_W'(1) << (FRAC_W + 1)))
    else $error("distance above two");

endmodule

bind hankel_pair_dynamic_distance hpdd_checker u_hpdd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_if.valid),
  .in_ready_i  (in_if.ready),
  .last_i      (in_if.last_element),
  .out_valid_i (out_if.valid),
  .out_ready_i (out_if.ready),
  .distance_i  (out_if.distance)
);

`default_nettype wire
